@@ rtl/pbec_pkg.sv @@
// ----------------------------------------------------------------------------
// pbec_pkg
// Shared types and constants for the panel blink effect controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pbec_pkg;

	// Widths fixed by the item layout
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned NOW_W    = 16;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned M_DATA_W = 32;

	// Commands, carried on s_tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 3'd0,
		CMD_BLINK      = 3'd1,
		CMD_STOP_MSG   = 3'd2,
		CMD_TWINKLE    = 3'd3,
		CMD_FLASH      = 3'd4,
		CMD_STOP_LEDS  = 3'd5
	} cmd_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MSG_DARK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MSG_LIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLASH_DARK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLASH_LIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TWK_STEP   = 3'd4;

	// Register reset values (ms)
	localparam logic [CFG_W-1:0] MSG_DARK_RST   = 16'd200;
	localparam logic [CFG_W-1:0] MSG_LIT_RST    = 16'd400;
	localparam logic [CFG_W-1:0] FLASH_DARK_RST = 16'd100;
	localparam logic [CFG_W-1:0] FLASH_LIT_RST  = 16'd200;
	localparam logic [CFG_W-1:0] TWK_STEP_RST   = 16'd300;

	// Result layout in m_tdata
	localparam int unsigned M_LIT_BIT    = 0;
	localparam int unsigned M_IDX_LO     = 1;
	localparam int unsigned M_ACTIVE_BIT = 4;
	localparam int unsigned M_GREEN_LO   = 5;
	localparam int unsigned M_RED_LO     = 13;
	localparam int unsigned M_PRESS_LO   = 21;

endpackage

`default_nettype wire

@@ rtl/panel_blink_effect_controller.sv @@
// ----------------------------------------------------------------------------
// panel_blink_effect_controller
// Message blink, LED flash / twinkle and button press reporting for a panel.
// ----------------------------------------------------------------------------
// Takes one command per clock on the slave stream and returns one result per
// command on the master stream in the cycle after its transfer. The effect
// state and the result register are updated in the same cycle as the transfer,
// so the block sustains one item per clock; the only stall is back-pressure
// from m_tready while the result register is full. Phase deadlines advance by
// the phase length and wrap modulo 2^TIME_BITS; each tick makes at most one
// phase change per effect. Configuration writes take effect on the next item.
`default_nettype none

module panel_blink_effect_controller #(
	parameter int unsigned LED_COUNT = 8,
	parameter int unsigned TIME_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// buttons[35:28] random_value[27:20] use_green[19] message_index[18:16]
	// now_ms[15:0]
	input  wire logic [pbec_pkg::S_DATA_W-1:0]       s_tdata,
	// command[2:0]
	input  wire logic [pbec_pkg::CMD_W-1:0]          s_tuser,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// new_presses[28:21] red_leds[20:13] green_leds[12:5] message_active[4]
	// shown_index[3:1] display_lit[0]
	output logic [pbec_pkg::M_DATA_W-1:0]            m_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic                                cfg_we,
	input  wire logic [pbec_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pbec_pkg::CFG_W-1:0]          cfg_data
);

	typedef enum logic [1:0] {
		MSG_OFF  = 2'd0,
		MSG_DARK = 2'd1,
		MSG_LIT  = 2'd2
	} msg_phase_t;

	typedef enum logic [1:0] {
		LED_OFF     = 2'd0,
		LED_DARK    = 2'd1,
		LED_LIT     = 2'd2,
		LED_TWINKLE = 2'd3
	} led_mode_t;

	localparam logic [2:0] PICK_MASK = 3'(LED_COUNT - 1);

	// configuration
	logic [pbec_pkg::CFG_W-1:0] msg_dark_q, msg_lit_q, flash_dark_q, flash_lit_q, twk_step_q;

	// effect state
	msg_phase_t                  msg_phase_q, msg_phase_d;
	logic [pbec_pkg::IDX_W-1:0]  blink_idx_q, blink_idx_d;
	logic [TIME_BITS-1:0]        msg_mark_q, msg_mark_d;
	led_mode_t                   led_mode_q, led_mode_d;
	logic [TIME_BITS-1:0]        led_mark_q, led_mark_d;
	logic [LED_COUNT-1:0]        twinkle_q, twinkle_d;
	logic                        led_green_q, led_green_d;
	logic [pbec_pkg::BYTE_W-1:0] buttons_q, buttons_d;

	// result register
	logic                         out_valid_q;
	logic [pbec_pkg::M_DATA_W-1:0] out_data_q;

	// unpacked input item
	pbec_pkg::cmd_t              cmd;
	logic [pbec_pkg::NOW_W-1:0]  now_ms;
	logic [pbec_pkg::IDX_W-1:0]  msg_idx;
	logic                        use_green;
	logic [pbec_pkg::BYTE_W-1:0] rnd;
	logic [pbec_pkg::BYTE_W-1:0] btn;

	logic                        in_xfer;
	logic [TIME_BITS-1:0]        now_ext;
	logic [pbec_pkg::CFG_W-1:0]  msg_len, led_len;
	logic                        msg_due, led_due;
	logic [2:0]                  pick;
	logic [LED_COUNT-1:0]        toggle;
	logic [LED_COUNT-1:0]        leds;
	logic [pbec_pkg::BYTE_W-1:0] leds8, presses;
	logic [pbec_pkg::M_DATA_W-1:0] result;

	assign cmd       = pbec_pkg::cmd_t'(s_tuser);
	assign now_ms    = s_tdata[15:0];
	assign msg_idx   = s_tdata[18:16];
	assign use_green = s_tdata[19];
	assign rnd       = s_tdata[27:20];
	assign btn       = s_tdata[35:28];

	assign s_tready = !out_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign now_ext = TIME_BITS'(now_ms);
	assign msg_len = (msg_phase_q == MSG_DARK) ? msg_dark_q : msg_lit_q;
	assign msg_due = (now_ext - msg_mark_q) >= TIME_BITS'(msg_len);

	always_comb begin
		case (led_mode_q)
			LED_DARK: led_len = flash_dark_q;
			LED_LIT:  led_len = flash_lit_q;
			default:  led_len = twk_step_q;
		endcase
	end
	assign led_due = (now_ext - led_mark_q) >= TIME_BITS'(led_len);

	// twinkle pick always lands below LED_COUNT
	assign pick = rnd[2:0] & PICK_MASK;
	always_comb begin
		for (int i = 0; i < LED_COUNT; i++) begin
			toggle[i] = (pick == 3'(i));
		end
	end

	always_comb begin
		msg_phase_d = msg_phase_q;
		blink_idx_d = blink_idx_q;
		msg_mark_d  = msg_mark_q;
		led_mode_d  = led_mode_q;
		led_mark_d  = led_mark_q;
		twinkle_d   = twinkle_q;
		led_green_d = led_green_q;
		buttons_d   = buttons_q;
		presses     = '0;
		case (cmd)
			pbec_pkg::CMD_TICK: begin
				if (msg_phase_q != MSG_OFF && msg_due) begin
					msg_mark_d  = msg_mark_q + TIME_BITS'(msg_len);
					msg_phase_d = (msg_phase_q == MSG_DARK) ? MSG_LIT : MSG_DARK;
				end
				if (led_mode_q != LED_OFF && led_due) begin
					led_mark_d = led_mark_q + TIME_BITS'(led_len);
					if (led_mode_q == LED_TWINKLE) begin
						twinkle_d = twinkle_q ^ toggle;
					end else begin
						led_mode_d = (led_mode_q == LED_DARK) ? LED_LIT : LED_DARK;
					end
				end
				presses   = btn & ~buttons_q;
				buttons_d = btn;
			end
			pbec_pkg::CMD_BLINK: begin
				blink_idx_d = msg_idx;
				msg_phase_d = MSG_DARK;
				msg_mark_d  = now_ext;
			end
			pbec_pkg::CMD_STOP_MSG: begin
				msg_phase_d = MSG_OFF;
			end
			pbec_pkg::CMD_TWINKLE: begin
				twinkle_d   = rnd[LED_COUNT-1:0];
				led_green_d = use_green;
				led_mode_d  = LED_TWINKLE;
				led_mark_d  = now_ext;
			end
			pbec_pkg::CMD_FLASH: begin
				twinkle_d   = '0;
				led_green_d = use_green;
				led_mode_d  = LED_DARK;
				led_mark_d  = now_ext;
			end
			pbec_pkg::CMD_STOP_LEDS: begin
				led_mode_d = LED_OFF;
			end
			default: begin
			end
		endcase
	end

	// result is built from the updated state
	always_comb begin
		case (led_mode_d)
			LED_LIT:     leds = '1;
			LED_TWINKLE: leds = twinkle_d;
			default:     leds = '0;
		endcase
		leds8  = pbec_pkg::BYTE_W'(leds);
		result = '0;
		result[pbec_pkg::M_LIT_BIT]          = (msg_phase_d == MSG_LIT);
		result[pbec_pkg::M_IDX_LO +: 3]      = (msg_phase_d != MSG_OFF) ? blink_idx_d : '0;
		result[pbec_pkg::M_ACTIVE_BIT]       = (msg_phase_d != MSG_OFF);
		result[pbec_pkg::M_GREEN_LO +: 8]    = led_green_d ? leds8 : '0;
		result[pbec_pkg::M_RED_LO +: 8]      = led_green_d ? '0 : leds8;
		result[pbec_pkg::M_PRESS_LO +: 8]    = presses;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_dark_q   <= pbec_pkg::MSG_DARK_RST;
			msg_lit_q    <= pbec_pkg::MSG_LIT_RST;
			flash_dark_q <= pbec_pkg::FLASH_DARK_RST;
			flash_lit_q  <= pbec_pkg::FLASH_LIT_RST;
			twk_step_q   <= pbec_pkg::TWK_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pbec_pkg::REG_MSG_DARK:   msg_dark_q   <= cfg_data;
				pbec_pkg::REG_MSG_LIT:    msg_lit_q    <= cfg_data;
				pbec_pkg::REG_FLASH_DARK: flash_dark_q <= cfg_data;
				pbec_pkg::REG_FLASH_LIT:  flash_lit_q  <= cfg_data;
				pbec_pkg::REG_TWK_STEP:   twk_step_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_phase_q <= MSG_OFF;
			blink_idx_q <= '0;
			msg_mark_q  <= '0;
			led_mode_q  <= LED_OFF;
			led_mark_q  <= '0;
			twinkle_q   <= '0;
			led_green_q <= 1'b0;
			buttons_q   <= '0;
		end else if (in_xfer) begin
			msg_phase_q <= msg_phase_d;
			blink_idx_q <= blink_idx_d;
			msg_mark_q  <= msg_mark_d;
			led_mode_q  <= led_mode_d;
			led_mark_q  <= led_mark_d;
			twinkle_q   <= twinkle_d;
			led_green_q <= led_green_d;
			buttons_q   <= buttons_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_data_q <= result;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pbec_checker.sv @@
// ----------------------------------------------------------------------------
// pbec_checker
// Port-level checks for the panel blink effect controller.
// ----------------------------------------------------------------------------
`default_nettype none

module pbec_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic [pbec_pkg::S_DATA_W-1:0]  s_tdata,
	input wire logic [pbec_pkg::CMD_W-1:0]     s_tuser,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic [pbec_pkg::M_DATA_W-1:0]  m_tdata,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready
);

	logic s_xfer;
	assign s_xfer = s_tvalid && s_tready;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every transfer in gives a result on the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> m_tvalid)
		else $error("no result after input transfer");

	// presses are only reported for ticks
	a_press: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && s_tuser != pbec_pkg::CMD_TICK |=> m_tdata[28:21] == 8'd0)
		else $error("presses reported for a non-tick command");

	// a blink starts dark, showing the requested message
	a_blink: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && s_tuser == pbec_pkg::CMD_BLINK |=>
			m_tdata[4] && !m_tdata[0] && m_tdata[3:1] == $past(s_tdata[18:16]))
		else $error("blink start result wrong");

	// result fields stay consistent with each other
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[0] || m_tdata[4]) && (m_tdata[4] || m_tdata[3:1] == 3'd0)
			&& (m_tdata[12:5] == 8'd0 || m_tdata[20:13] == 8'd0))
		else $error("inconsistent result fields");

endmodule

bind panel_blink_effect_controller pbec_checker u_pbec_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

`default_nettype wire

@@ tb/tb_panel_blink_effect_controller.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_panel_blink_effect_controller
// Stream-level test of the panel blink effect controller. A queue of commands
// feeds a falling-edge driver; a rising-edge monitor predicts each panel state
// on the input transfer and checks every output transfer against it, field by
// field. Directed commands cover the phase edges, time wrap and zero-length
// registers; random phases follow under several register settings, maximum
// length included, with random gaps on both streams and long output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_panel_blink_effect_controller;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned LONG_HOLD     = 120;
	localparam logic [7:0]  LED_ALL       = 8'hff;
	localparam logic [15:0] T0            = 16'hfff0;
	// commands the block does not use, and the first unused register index
	localparam logic [pbec_pkg::CMD_W-1:0]     CMD_SPARE_A   = 3'd6;
	localparam logic [pbec_pkg::CMD_W-1:0]     CMD_SPARE_B   = 3'd7;
	localparam logic [pbec_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;

	typedef struct packed {
		logic [pbec_pkg::CMD_W-1:0]  cmd;
		logic [pbec_pkg::NOW_W-1:0]  now;
		logic [pbec_pkg::IDX_W-1:0]  idx;
		logic                        green;
		logic [pbec_pkg::BYTE_W-1:0] rnd;
		logic [pbec_pkg::BYTE_W-1:0] btn;
	} panel_cmd_t;

	typedef struct packed {
		logic                        lit;
		logic [pbec_pkg::IDX_W-1:0]  shown;
		logic                        active;
		logic [pbec_pkg::BYTE_W-1:0] green;
		logic [pbec_pkg::BYTE_W-1:0] red;
		logic [pbec_pkg::BYTE_W-1:0] presses;
	} panel_res_t;

	typedef enum logic [1:0] {MSG_OFF, MSG_DARK, MSG_LIT} msg_phase_t;
	typedef enum logic [1:0] {LED_OFF, FLASH_DARK, FLASH_LIT, TWINKLING} led_mode_t;

	logic                            clk;
	logic                            arst_n;
	logic [pbec_pkg::S_DATA_W-1:0]   s_tdata;
	logic [pbec_pkg::CMD_W-1:0]      s_tuser;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [pbec_pkg::M_DATA_W-1:0]   m_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic                            cfg_we;
	logic [pbec_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pbec_pkg::CFG_W-1:0]      cfg_data;

	panel_blink_effect_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted block state
	logic [pbec_pkg::CFG_W-1:0]  msg_dark_len   = pbec_pkg::MSG_DARK_RST;
	logic [pbec_pkg::CFG_W-1:0]  msg_lit_len    = pbec_pkg::MSG_LIT_RST;
	logic [pbec_pkg::CFG_W-1:0]  flash_dark_len = pbec_pkg::FLASH_DARK_RST;
	logic [pbec_pkg::CFG_W-1:0]  flash_lit_len  = pbec_pkg::FLASH_LIT_RST;
	logic [pbec_pkg::CFG_W-1:0]  twinkle_len    = pbec_pkg::TWK_STEP_RST;
	msg_phase_t                  msg_phase      = MSG_OFF;
	logic [pbec_pkg::IDX_W-1:0]  blink_idx      = '0;
	logic [pbec_pkg::NOW_W-1:0]  msg_mark       = '0;
	led_mode_t                   led_mode       = LED_OFF;
	logic [pbec_pkg::NOW_W-1:0]  led_mark       = '0;
	logic [pbec_pkg::BYTE_W-1:0] twinkle_bits   = '0;
	logic                        leds_green     = 1'b0;
	logic [pbec_pkg::BYTE_W-1:0] btn_seen       = '0;

	panel_cmd_t  cmd_backlog[$];
	panel_res_t  panel_forecast[$];
	panel_cmd_t  cur_item;
	logic        s_taken = 1'b0;
	logic        calm = 1'b0;
	int unsigned src_gap = 0;
	int unsigned sink_gap = 0;
	int unsigned hold_left = 0;
	int unsigned next_hold_at = 300;
	int unsigned in_count = 0;
	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	logic [pbec_pkg::NOW_W-1:0]  wall_ms = '0;
	logic [pbec_pkg::BYTE_W-1:0] btn_level = '0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_panel_blink_effect_controller NOT OK");
		$finish;
	end

	function automatic panel_res_t panel_advance(input panel_cmd_t c);
		logic [pbec_pkg::NOW_W-1:0]  span;
		logic [pbec_pkg::NOW_W-1:0]  elapsed;
		logic [pbec_pkg::BYTE_W-1:0] leds;
		panel_res_t                  r;
		r = '0;
		leds = '0;
		case (c.cmd)
			pbec_pkg::CMD_TICK: begin
				if (msg_phase != MSG_OFF) begin
					span = (msg_phase == MSG_DARK) ? msg_dark_len : msg_lit_len;
					elapsed = c.now - msg_mark;
					if (elapsed >= span) begin
						msg_mark = msg_mark + span;
						msg_phase = (msg_phase == MSG_DARK) ? MSG_LIT : MSG_DARK;
					end
				end
				if (led_mode != LED_OFF) begin
					span = (led_mode == FLASH_DARK) ? flash_dark_len :
						(led_mode == FLASH_LIT) ? flash_lit_len : twinkle_len;
					elapsed = c.now - led_mark;
					if (elapsed >= span) begin
						led_mark = led_mark + span;
						// low three bits pick one of the eight LEDs
						if (led_mode == TWINKLING)
							twinkle_bits[c.rnd[2:0]] = ~twinkle_bits[c.rnd[2:0]];
						else
							led_mode = (led_mode == FLASH_DARK) ? FLASH_LIT : FLASH_DARK;
					end
				end
				r.presses = c.btn & ~btn_seen;
				btn_seen = c.btn;
			end
			pbec_pkg::CMD_BLINK: begin
				blink_idx = c.idx;
				msg_phase = MSG_DARK;
				msg_mark = c.now;
			end
			pbec_pkg::CMD_STOP_MSG: msg_phase = MSG_OFF;
			pbec_pkg::CMD_TWINKLE: begin
				twinkle_bits = c.rnd;
				leds_green = c.green;
				led_mode = TWINKLING;
				led_mark = c.now;
			end
			pbec_pkg::CMD_FLASH: begin
				twinkle_bits = '0;
				leds_green = c.green;
				led_mode = FLASH_DARK;
				led_mark = c.now;
			end
			pbec_pkg::CMD_STOP_LEDS: led_mode = LED_OFF;
			default: ;
		endcase
		if (led_mode == FLASH_LIT)
			leds = LED_ALL;
		else if (led_mode == TWINKLING)
			leds = twinkle_bits;
		r.lit = (msg_phase == MSG_LIT);
		r.active = (msg_phase != MSG_OFF);
		r.shown = r.active ? blink_idx : '0;
		r.green = leds_green ? leds : '0;
		r.red = leds_green ? '0 : leds;
		return r;
	endfunction

	function automatic panel_cmd_t mk(input logic [pbec_pkg::CMD_W-1:0] cmd,
			input logic [pbec_pkg::NOW_W-1:0] now, input logic [pbec_pkg::IDX_W-1:0] idx,
			input logic green, input logic [pbec_pkg::BYTE_W-1:0] rnd,
			input logic [pbec_pkg::BYTE_W-1:0] btn);
		panel_cmd_t it;
		it.cmd = cmd;
		it.now = now;
		it.idx = idx;
		it.green = green;
		it.rnd = rnd;
		it.btn = btn;
		return it;
	endfunction

	// mostly ticks on a steadily advancing clock, so effects run through their phases
	function automatic panel_cmd_t random_item(input int unsigned step_max);
		panel_cmd_t  it;
		int unsigned roll;
		logic [2:0]  flip;
		roll = $urandom_range(0, 99);
		if (roll < 72)      it.cmd = pbec_pkg::CMD_TICK;
		else if (roll < 77) it.cmd = pbec_pkg::CMD_BLINK;
		else if (roll < 80) it.cmd = pbec_pkg::CMD_STOP_MSG;
		else if (roll < 86) it.cmd = pbec_pkg::CMD_TWINKLE;
		else if (roll < 92) it.cmd = pbec_pkg::CMD_FLASH;
		else if (roll < 96) it.cmd = pbec_pkg::CMD_STOP_LEDS;
		else if (roll < 98) it.cmd = CMD_SPARE_A;
		else                it.cmd = CMD_SPARE_B;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			wall_ms = wall_ms + pbec_pkg::NOW_W'($urandom_range(0, step_max));
		else if (roll < 92)
			wall_ms = wall_ms + pbec_pkg::NOW_W'($urandom_range(0, 1000));
		else
			wall_ms = wall_ms + pbec_pkg::NOW_W'($urandom);
		// now and then a time out of order
		it.now = ($urandom_range(0, 49) == 0) ? pbec_pkg::NOW_W'($urandom) : wall_ms;
		if ($urandom_range(0, 9) < 4) begin
			btn_level = pbec_pkg::BYTE_W'($urandom);
		end else begin
			flip = 3'($urandom_range(0, pbec_pkg::BYTE_W-1));
			btn_level[flip] = ~btn_level[flip];
		end
		it.btn = btn_level;
		it.idx = pbec_pkg::IDX_W'($urandom);
		it.green = 1'($urandom);
		it.rnd = pbec_pkg::BYTE_W'($urandom);
		return it;
	endfunction

	task automatic write_reg(input logic [pbec_pkg::CFG_IDX_W-1:0] idx,
			input logic [pbec_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			pbec_pkg::REG_MSG_DARK:   msg_dark_len = val;
			pbec_pkg::REG_MSG_LIT:    msg_lit_len = val;
			pbec_pkg::REG_FLASH_DARK: flash_dark_len = val;
			pbec_pkg::REG_FLASH_LIT:  flash_lit_len = val;
			pbec_pkg::REG_TWK_STEP:   twinkle_len = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_regs(input logic [pbec_pkg::CFG_W-1:0] a,
			input logic [pbec_pkg::CFG_W-1:0] b, input logic [pbec_pkg::CFG_W-1:0] c,
			input logic [pbec_pkg::CFG_W-1:0] d, input logic [pbec_pkg::CFG_W-1:0] e);
		write_reg(pbec_pkg::REG_MSG_DARK, a);
		write_reg(pbec_pkg::REG_MSG_LIT, b);
		write_reg(pbec_pkg::REG_FLASH_DARK, c);
		write_reg(pbec_pkg::REG_FLASH_LIT, d);
		write_reg(pbec_pkg::REG_TWK_STEP, e);
		// unused index, must change nothing
		write_reg(pbec_pkg::CFG_IDX_W'($urandom_range(7, REG_UNUSED_LO)),
			pbec_pkg::CFG_W'($urandom));
	endtask

	task automatic queue_random(input int unsigned count, input int unsigned step_max);
		repeat (count) cmd_backlog.push_back(random_item(step_max));
	endtask

	// sender pauses until every panel state has come back
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (cmd_backlog.size() != 0 || s_tvalid || panel_forecast.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	// driver: one command per transfer, random gaps between transfers
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_taken)) begin
			s_taken = 1'b0;
			if (src_gap != 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				cur_item = cmd_backlog.pop_front();
				s_tdata <= {4'b0, cur_item.btn, cur_item.rnd, cur_item.green, cur_item.idx,
					cur_item.now};
				s_tuser <= cur_item.cmd;
				s_tvalid <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 5);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: short random stalls, plus a long hold now and then to back up the input
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!calm && in_count >= next_hold_at) begin
			hold_left = LONG_HOLD;
			next_hold_at = next_hold_at + 700;
			m_tready <= 1'b0;
		end else if (sink_gap != 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!calm && $urandom_range(0, 5) == 0)
				sink_gap = $urandom_range(1, 5);
		end
	end

	// monitor: predict on each input transfer, check each output transfer
	always @(posedge clk) begin : monitor
		panel_res_t want;
		panel_res_t seen;
		if (m_tvalid && m_tready) begin
			seen.lit = m_tdata[pbec_pkg::M_LIT_BIT];
			seen.shown = m_tdata[pbec_pkg::M_IDX_LO +: pbec_pkg::IDX_W];
			seen.active = m_tdata[pbec_pkg::M_ACTIVE_BIT];
			seen.green = m_tdata[pbec_pkg::M_GREEN_LO +: pbec_pkg::BYTE_W];
			seen.red = m_tdata[pbec_pkg::M_RED_LO +: pbec_pkg::BYTE_W];
			seen.presses = m_tdata[pbec_pkg::M_PRESS_LO +: pbec_pkg::BYTE_W];
			if (panel_forecast.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time, seen);
				err_count++;
			end else begin
				want = panel_forecast.pop_front();
				check_field("display_lit", 32'(want.lit), 32'(seen.lit));
				check_field("shown_index", 32'(want.shown), 32'(seen.shown));
				check_field("message_active", 32'(want.active), 32'(seen.active));
				check_field("green_leds", 32'(want.green), 32'(seen.green));
				check_field("red_leds", 32'(want.red), 32'(seen.red));
				check_field("new_presses", 32'(want.presses), 32'(seen.presses));
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			s_taken = 1'b1;
			in_count++;
			panel_forecast.push_back(panel_advance(cur_item));
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: button edges, time wrap, one phase change per tick
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, 16'h0000, 3'd0, 1'b0, 8'h00, 8'hff));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, 16'hffff, 3'd7, 1'b1, 8'hff, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, 16'h0001, 3'd0, 1'b0, 8'h00, 8'h5a));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_BLINK, T0, 3'd7, 1'b1, 8'hff, 8'hff));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, T0 + 16'd199, 3'd0, 1'b0, 8'h00, 8'hff));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, T0 + 16'd200, 3'd0, 1'b0, 8'h00, 8'hff));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, T0 + 16'd1000, 3'd0, 1'b0, 8'h00, 8'h0f));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, T0 + 16'd1000, 3'd0, 1'b0, 8'h00, 8'hf0));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TWINKLE, T0 + 16'd1000, 3'd0, 1'b1, 8'ha5,
			8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, T0 + 16'd1300, 3'd0, 1'b0, 8'h07, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, T0 + 16'd1600, 3'd0, 1'b0, 8'hf8, 8'h81));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_FLASH, T0 + 16'd1600, 3'd5, 1'b0, 8'hff, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, T0 + 16'd1700, 3'd0, 1'b0, 8'h00, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, T0 + 16'd1900, 3'd0, 1'b0, 8'h00, 8'h00));
		cmd_backlog.push_back(mk(CMD_SPARE_A, 16'h1234, 3'd3, 1'b1, 8'h3c, 8'hff));
		cmd_backlog.push_back(mk(CMD_SPARE_B, 16'hffff, 3'd7, 1'b1, 8'hff, 8'hff));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_STOP_MSG, T0, 3'd0, 1'b0, 8'h00, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_STOP_LEDS, T0, 3'd0, 1'b0, 8'h00, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, T0 + 16'd1900, 3'd0, 1'b0, 8'h00, 8'hff));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_BLINK, T0 + 16'd2000, 3'd0, 1'b0, 8'h00, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_FLASH, T0 + 16'd2000, 3'd0, 1'b1, 8'h00, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, T0 + 16'd2100, 3'd0, 1'b0, 8'h00, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TWINKLE, T0 + 16'd2100, 3'd0, 1'b0, 8'hff,
			8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, T0 + 16'd2400, 3'd0, 1'b0, 8'h00, 8'h00));
		drain();

		// zero-length phases: every tick changes phase and marks stay put
		load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		cmd_backlog.push_back(mk(pbec_pkg::CMD_BLINK, 16'd5, 3'd2, 1'b0, 8'h00, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_FLASH, 16'd5, 3'd0, 1'b1, 8'h00, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, 16'd5, 3'd0, 1'b0, 8'h00, 8'h01));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, 16'd4, 3'd0, 1'b0, 8'h00, 8'h03));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TWINKLE, 16'd9, 3'd0, 1'b0, 8'h11, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, 16'd9, 3'd0, 1'b0, 8'h03, 8'h00));
		cmd_backlog.push_back(mk(pbec_pkg::CMD_TICK, 16'd9, 3'd0, 1'b0, 8'h03, 8'h00));
		drain();

		load_regs(pbec_pkg::CFG_W'($urandom_range(1, 16)), pbec_pkg::CFG_W'($urandom_range(1, 16)),
			pbec_pkg::CFG_W'($urandom_range(1, 16)), pbec_pkg::CFG_W'($urandom_range(1, 16)),
			pbec_pkg::CFG_W'($urandom_range(1, 16)));
		queue_random(300, 10);
		drain();

		load_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		queue_random(200, 60);
		drain();

		load_regs(16'd1, 16'hffff, 16'hffff, 16'd1, 16'd1);
		queue_random(200, 40);
		drain();

		load_regs(pbec_pkg::CFG_W'($urandom_range(1, 65535)),
			pbec_pkg::CFG_W'($urandom_range(1, 65535)),
			pbec_pkg::CFG_W'($urandom_range(1, 65535)),
			pbec_pkg::CFG_W'($urandom_range(1, 65535)),
			pbec_pkg::CFG_W'($urandom_range(1, 65535)));
		queue_random(300, 2000);
		drain();

		// back to reset values, both streams at full rate
		load_regs(pbec_pkg::MSG_DARK_RST, pbec_pkg::MSG_LIT_RST, pbec_pkg::FLASH_DARK_RST,
			pbec_pkg::FLASH_LIT_RST, pbec_pkg::TWK_STEP_RST);
		calm = 1'b1;
		queue_random(400, 60);
		drain();

		if (err_count == 0 && panel_forecast.size() == 0)
			$display("tb_panel_blink_effect_controller OK");
		else
			$display("tb_panel_blink_effect_controller NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/pbec_pkg.sv
rtl/panel_blink_effect_controller.sv
rtl/pbec_checker.sv
tb/tb_panel_blink_effect_controller.sv
